// ===== rtl/core/tce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CHAR_W = 8;

  // Command codes
  localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
  localparam logic [2:0] CMD_WRITE_CELL = 3'd1;
  localparam logic [2:0] CMD_READ_CELL  = 3'd2;
  localparam logic [2:0] CMD_SET_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [4:0] row_index;
    logic [6:0] column_index;
    logic [3:0] fore_color;
    logic [3:0] back_color;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_line;
    logic [6:0]  cursor_column;
    logic [15:0] cell_value;
    logic        scrolled;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/text_console_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a ROWS x COLS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) plus a cursor.
// Channels: the input channel (in_valid_i/in_ready_o/in_data_i) carries one
// command per transaction; the output channel (out_valid_o/out_ready_i/
// out_data_o) returns exactly one result per command, in order. The config
// channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the text attribute; it
// is always ready and is meant to be written while the engine is idle.
// Timing: one screen RAM port pair and one address multiplier are shared among
// the commands under a small sequencer. A plain command (write, read, set
// cursor, simple put) passes through an execute and a finish state; the engine
// takes a new command only when idle, after the previous result is registered.
// A scroll then copies each row up one (read then write per cell) and blanks
// the last row. Clear blanks every cell, one cell per cycle.
// Reset: the cursor goes to 0,0, the attribute to 0x0F, and a clearing pass
// writes zero to every cell; in_ready_o stays low until it ends. Stall: a
// finished result sits in an output register; the engine takes the next
// command meanwhile but holds its own result until the previous one is taken.
module text_console_engine #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire tce_pkg::in_item_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output tce_pkg::out_item_t             out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [tce_pkg::ATTR_W-1:0] cfg_data_i
);
  import tce_pkg::*;

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RWP   = RW + 1;
  localparam int unsigned CWP   = CW + 1;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_SCR_RD = 3'd3;
  localparam logic [2:0] ST_SCR_WR = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              scrolled_q, scrolled_d;
  logic [ATTR_W-1:0] attr_q;
  in_item_t          item_q;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [CELL_W-1:0] blank;
  logic              item_in_range;
  logic              out_free;

  // Put-character decode
  logic [RWP-1:0]    pc_row_n;
  logic [CWP-1:0]    pc_col_n;
  logic [CWP-1:0]    tab_sum;
  logic              pc_we;
  logic [CW-1:0]     pc_wcol;
  logic [CELL_W-1:0] pc_wdata;
  logic              pc_scroll;

  // Shared address unit
  logic [RW-1:0]     a_row;
  logic [CW-1:0]     a_col;
  logic [AW-1:0]     mul_addr;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign blank         = {attr_q, CH_SPACE};
  assign item_in_range = (32'(item_q.row_index) < ROWS) && (32'(item_q.column_index) < COLS);
  assign in_ready_o    = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;
  assign out_free      = !out_valid_q || out_ready_i;

  // Put character: cursor motion, wrap and scroll decision
  always_comb begin
    pc_row_n  = {1'b0, row_q};
    pc_col_n  = {1'b0, col_q};
    tab_sum   = {1'b0, col_q} + CWP'(8);
    pc_we     = 1'b0;
    pc_wcol   = col_q;
    pc_wdata  = {attr_q, item_q.char_code};
    pc_scroll = 1'b0;
    priority if (item_q.char_code == CH_NL) begin
      pc_col_n = '0;
      pc_row_n = pc_row_n + RWP'(1);
    end else if (item_q.char_code == CH_CR) begin
      pc_col_n = '0;
    end else if (item_q.char_code == CH_BS) begin
      if (col_q != '0) begin
        pc_col_n = {1'b0, col_q} - CWP'(1);
        pc_we    = 1'b1;
        pc_wcol  = col_q - CW'(1);
        pc_wdata = blank;
      end
    end else if (item_q.char_code == CH_TAB) begin
      pc_col_n = {tab_sum[CW:3], 3'b000};
    end else begin
      pc_we    = 1'b1;
      pc_col_n = {1'b0, col_q} + CWP'(1);
    end
    // Wrap at line end
    if (32'(pc_col_n) >= COLS) begin
      pc_col_n = '0;
      pc_row_n = pc_row_n + RWP'(1);
    end
    pc_scroll = (32'(pc_row_n) >= ROWS);
  end

  // Address unit: row * COLS + column, shared by put, write and read
  always_comb begin
    if (item_q.command == CMD_PUT_CHAR) begin
      a_row = row_q;
      a_col = pc_wcol;
    end else begin
      a_row = RW'(item_q.row_index);
      a_col = CW'(item_q.column_index);
    end
    mul_addr = AW'(AW'(a_row) * AW'(COLS)) + AW'(a_col);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    ptr_d       = ptr_q;
    scrolled_d  = scrolled_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = blank;
    ram_re      = 1'b0;
    ram_raddr   = mul_addr;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ptr_d     = ptr_q + AW'(1);
        if (32'(ptr_q) == CELLS - 1) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        scrolled_d = 1'b0;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_FIN;
        unique case (item_q.command)
          CMD_PUT_CHAR: begin
            ram_we    = pc_we;
            ram_waddr = mul_addr;
            ram_wdata = pc_wdata;
            col_d     = CW'(pc_col_n);
            if (pc_scroll) begin
              row_d      = RW'(ROWS - 1);
              scrolled_d = 1'b1;
              ptr_d      = '0;
              state_d    = ST_SCR_RD;
            end else begin
              row_d = RW'(pc_row_n);
            end
          end
          CMD_WRITE_CELL: begin
            ram_we    = item_in_range;
            ram_waddr = mul_addr;
            ram_wdata = {item_q.back_color, item_q.fore_color, item_q.char_code};
          end
          CMD_READ_CELL: begin
            ram_re = item_in_range;
          end
          CMD_SET_CURSOR: begin
            row_d = (32'(item_q.row_index) >= ROWS) ? RW'(ROWS - 1)
                                                    : RW'(item_q.row_index);
            col_d = (32'(item_q.column_index) >= COLS) ? CW'(COLS - 1)
                                                       : CW'(item_q.column_index);
          end
          CMD_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            ptr_d   = '0;
            state_d = ST_FILL;
          end
          default: begin
          end
        endcase
      end
      ST_SCR_RD: begin
        // Fetch the cell one row below
        ram_re    = 1'b1;
        ram_raddr = ptr_q + AW'(COLS);
        state_d   = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_q + AW'(1);
        state_d   = ST_SCR_RD;
        if (32'(ptr_q) == CELLS - COLS - 1) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
        if (32'(ptr_q) == CELLS - 1) begin
          ptr_d   = '0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_d.cursor_line   = 5'(row_q);
          out_d.cursor_column = 7'(col_q);
          out_d.cell_value    = '0;
          if (item_q.command == CMD_READ_CELL) begin
            out_d.cell_value = item_in_range ? ram_rdata : blank;
          end
          out_d.scrolled = scrolled_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      scrolled_q  <= 1'b0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      scrolled_q  <= scrolled_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  tce_screen_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Cursor stays on screen
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLS))
    else $error("cursor left the screen");

  // Scroll copy never reads past the last cell
  a_scroll_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR_RD) |-> (32'(ptr_q) < CELLS - COLS))
    else $error("scroll pointer out of range");

  // A scrolled result always leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && scrolled_q) |-> (row_q == RW'(ROWS - 1)))
    else $error("scroll left cursor off last row");

  // No RAM write while waiting for a command or delivering a result
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FIN) |-> !ram_we)
    else $error("screen write outside a command");

endmodule

`default_nettype wire

// ===== rtl/core/tce_screen_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tce_screen_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [tce_pkg::CELL_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [tce_pkg::CELL_W-1:0] rdata_o
);
  import tce_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sim/text_console_checker.sv =====
`timescale 1ns / 1ps

// Mirrors the console screen and cursor, predicts one result per accepted
// command and compares each returned result, oldest first.
module text_console_checker #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  logic                       cmd_ready_i,
  input  tce_pkg::in_item_t          cmd_i,
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  tce_pkg::out_item_t         res_i,
  input  logic                       attr_valid_i,
  input  logic                       attr_ready_i,
  input  logic [tce_pkg::ATTR_W-1:0] attr_i,
  output int                         mismatch_count_o,
  output int                         pending_count_o,
  output int                         scroll_count_o
);
  import tce_pkg::*;

  logic [CELL_W-1:0] screen [ROWS*COLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] attr;
  out_item_t         awaited_results [$];
  int                mismatch_total;
  int                scroll_total;

  function automatic logic [CELL_W-1:0] blank_glyph();
    return {attr, CH_SPACE};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i + COLS < ROWS * COLS; i++) screen[i] = screen[i + COLS];
    for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) screen[i] = blank_glyph();
    if (cur_row > 0) cur_row--;
  endfunction

  // Returns 1 when the character pushed the screen up one row.
  function automatic logic put_glyph(input logic [CHAR_W-1:0] ch);
    int unsigned r;
    int unsigned c;
    logic        rolled;
    r = cur_row;
    c = cur_col;
    rolled = 1'b0;
    case (ch)
      CH_NL: begin
        c = 0;
        r++;
      end
      CH_CR: c = 0;
      CH_BS: begin
        if (c > 0 && r < ROWS) begin
          c--;
          screen[r * COLS + c] = blank_glyph();
          cur_col = c;
        end
        return 1'b0;
      end
      CH_TAB: c = (c + 8) & ~32'd7;
      default: begin
        if (r < ROWS && c < COLS) screen[r * COLS + c] = {attr, ch};
        c++;
      end
    endcase
    if (c >= COLS) begin
      c = 0;
      r++;
    end
    cur_row = r;
    cur_col = c;
    if (cur_row >= ROWS) begin
      scroll_screen();
      rolled = 1'b1;
    end
    if (cur_row >= ROWS) cur_row = ROWS - 1;
    if (cur_col >= COLS) cur_col = COLS - 1;
    return rolled;
  endfunction

  function automatic out_item_t apply_command(input in_item_t cmd);
    out_item_t         res;
    logic [CELL_W-1:0] word;
    logic              rolled;
    logic              in_range;
    int unsigned       at;
    word = '0;
    rolled = 1'b0;
    in_range = (cmd.row_index < ROWS) && (cmd.column_index < COLS);
    at = cmd.row_index * COLS + cmd.column_index;
    case (cmd.command)
      CMD_PUT_CHAR: rolled = put_glyph(cmd.char_code);
      CMD_WRITE_CELL: begin
        if (in_range) screen[at] = {cmd.back_color, cmd.fore_color, cmd.char_code};
      end
      CMD_READ_CELL: word = in_range ? screen[at] : blank_glyph();
      CMD_SET_CURSOR: begin
        cur_row = (cmd.row_index >= ROWS) ? ROWS - 1 : cmd.row_index;
        cur_col = (cmd.column_index >= COLS) ? COLS - 1 : cmd.column_index;
      end
      CMD_CLEAR: begin
        foreach (screen[i]) screen[i] = blank_glyph();
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    res.cursor_line   = 5'(cur_row);
    res.cursor_column = 7'(cur_col);
    res.cell_value    = word;
    res.scrolled      = rolled;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_total++;
    if (mismatch_total <= 40)
      $display("%0t ns: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (screen[i]) screen[i] = '0;
      cur_row = 0;
      cur_col = 0;
      attr = ATTR_RESET;
      awaited_results.delete();
      mismatch_total = 0;
      scroll_total = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
      scroll_count_o <= 0;
    end else begin
      // Check the returned result before this edge's command is predicted.
      if (res_valid_i && res_ready_i) begin
        if (res_i.scrolled) scroll_total++;
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with no command pending", 32'(res_i), 0);
        end else begin
          want = awaited_results.pop_front();
          if (res_i.cursor_line !== want.cursor_line)
            flag_mismatch("cursor_line", 32'(res_i.cursor_line),
                          32'(want.cursor_line));
          if (res_i.cursor_column !== want.cursor_column)
            flag_mismatch("cursor_column", 32'(res_i.cursor_column),
                          32'(want.cursor_column));
          if (res_i.cell_value !== want.cell_value)
            flag_mismatch("cell_value", 32'(res_i.cell_value), 32'(want.cell_value));
          if (res_i.scrolled !== want.scrolled)
            flag_mismatch("scrolled", 32'(res_i.scrolled), 32'(want.scrolled));
        end
      end
      if (attr_valid_i && attr_ready_i) attr = attr_i;
      if (cmd_valid_i && cmd_ready_i) awaited_results.push_back(apply_command(cmd_i));
      mismatch_count_o <= mismatch_total;
      pending_count_o <= awaited_results.size();
      scroll_count_o <= scroll_total;
    end
  end

endmodule

// ===== sim/text_console_engine_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the text console engine. A checker instance beside
// the block mirrors the screen and compares every result transaction.
module text_console_engine_test;
  import tce_pkg::*;

  localparam int unsigned ROWS = 25;
  localparam int unsigned COLS = 80;
  localparam int unsigned ITEM_TARGET = 1450;
  // Receiver hold-off long enough to back the engine up into its input.
  localparam int unsigned HOLD_CYCLES = 400;
  // Scrolls and clears each rewrite the whole screen; keep their number bounded.
  localparam int unsigned SCROLL_BUDGET = 80;
  localparam int unsigned CLEAR_BUDGET = 30;
  localparam int unsigned SETTLE_CYCLES = 2 * ROWS * COLS + COLS;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST = 3'd7;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  in_item_t          in_data_i = '0;
  logic              out_ready_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [ATTR_W-1:0] cfg_data_i = ATTR_RESET;
  logic              in_ready_o;
  logic              out_valid_o;
  out_item_t         out_data_o;
  logic              cfg_ready_o;

  int                mismatches;
  int                pending;
  int                scrolls;
  int unsigned       sent_count = 0;
  int unsigned       clear_count = 0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       receiver_stall_pct = 0;
  logic              hold_pending = 1'b0;

  // Idle pattern per phase: none, sender only, receiver only, both lightly.
  int unsigned       sender_idle_plan [4] = '{0, 47, 0, 9};
  int unsigned       receiver_stall_plan [4] = '{0, 0, 47, 9};
  logic [ATTR_W-1:0] attr_plan [3] = '{8'h00, 8'hFF, 8'h5A};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  text_console_engine #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  text_console_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) shadow (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (in_valid_i),
    .cmd_ready_i     (in_ready_o),
    .cmd_i           (in_data_i),
    .res_valid_i     (out_valid_o),
    .res_ready_i     (out_ready_i),
    .res_i           (out_data_o),
    .attr_valid_i    (cfg_valid_i),
    .attr_ready_i    (cfg_ready_o),
    .attr_i          (cfg_data_i),
    .mismatch_count_o(mismatches),
    .pending_count_o (pending),
    .scroll_count_o  (scrolls)
  );

  // Result side: stall at the phase's rate, and on request hold ready low for
  // a long counted stretch so the engine fills up and stalls its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Build a command transaction; colors are random unless overridden.
  function automatic in_item_t cmd_item(input logic [2:0] op, input logic [7:0] ch,
                                        input logic [4:0] row, input logic [6:0] col);
    in_item_t item;
    item.command      = op;
    item.char_code    = ch;
    item.row_index    = row;
    item.column_index = col;
    item.fore_color   = 4'($urandom_range(15));
    item.back_color   = 4'($urandom_range(15));
    return item;
  endfunction

  // Mostly on-screen positions, sometimes anywhere the field allows.
  function automatic logic [4:0] pick_row();
    return ($urandom_range(9) < 8) ? 5'($urandom_range(ROWS - 1)) : 5'($urandom);
  endfunction

  function automatic logic [6:0] pick_col();
    return ($urandom_range(9) < 8) ? 7'($urandom_range(COLS - 1)) : 7'($urandom);
  endfunction

  // Printable text with a fair share of control characters mixed in.
  function automatic logic [7:0] pick_glyph();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return CH_NL;
    if (p < 15) return CH_CR;
    if (p < 22) return CH_BS;
    if (p < 29) return CH_TAB;
    if (p < 35) return CH_SPACE;
    return 8'($urandom);
  endfunction

  // Offer one command; optionally idle first, then hold valid and payload
  // until the transaction is accepted.
  task automatic send(input in_item_t item);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if (item.command == CMD_CLEAR) clear_count++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random burst: a run of text, a group of cell writes read back, or a
  // loose command. Once the scroll budget is spent, text starts near the top.
  task automatic run_burst();
    int unsigned kind;
    int unsigned n;
    int unsigned p;
    logic [4:0]  rows [6];
    logic [6:0]  cols [6];
    kind = $urandom_range(99);
    if (kind < 50) begin
      if (scrolls >= SCROLL_BUDGET)
        send(cmd_item(CMD_SET_CURSOR, 8'($urandom), 5'($urandom_range(ROWS / 4)),
                      7'($urandom)));
      else if ($urandom_range(2) == 0)
        send(cmd_item(CMD_SET_CURSOR, 8'($urandom), 5'($urandom), 7'($urandom)));
      n = $urandom_range(14, 3);
      repeat (n) send(cmd_item(CMD_PUT_CHAR, pick_glyph(), 5'($urandom), 7'($urandom)));
      if ($urandom_range(1))
        send(cmd_item(CMD_READ_CELL, 8'($urandom), pick_row(), pick_col()));
    end else if (kind < 80) begin
      n = $urandom_range(6, 2);
      for (int i = 0; i < n; i++) begin
        rows[i] = pick_row();
        cols[i] = pick_col();
        send(cmd_item(CMD_WRITE_CELL, 8'($urandom), rows[i], cols[i]));
      end
      for (int i = n - 1; i >= 0; i--)
        send(cmd_item(CMD_READ_CELL, 8'($urandom), rows[i], cols[i]));
    end else begin
      p = $urandom_range(99);
      if (p < 30)
        send(cmd_item(CMD_READ_CELL, 8'($urandom), 5'($urandom), 7'($urandom)));
      else if (p < 55)
        send(cmd_item(CMD_SET_CURSOR, 8'($urandom), 5'($urandom), 7'($urandom)));
      else if (p < 75)
        send(cmd_item(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), 8'($urandom),
                      5'($urandom), 7'($urandom)));
      else if (clear_count < CLEAR_BUDGET)
        send(cmd_item(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)));
      else
        send(cmd_item(CMD_READ_CELL, 8'($urandom), pick_row(), pick_col()));
    end
  endtask

  initial begin
    in_item_t          item;
    int unsigned       phase_end;
    logic [ATTR_W-1:0] phase_attr;

    // Hold reset, then release it; the engine then runs its clearing pass
    // with in_ready_o low, which send() simply waits out.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_attribute(8'h1E);

    // Directed: field extremes, every command, each special character,
    // wrap and scroll at the bottom corner, out-of-range positions.
    send(cmd_item(CMD_READ_CELL, 8'h00, 5'd0, 7'd0));
    send(cmd_item(CMD_READ_CELL, 8'h00, 5'h1F, 7'h7F));
    item = cmd_item(CMD_WRITE_CELL, 8'hFF, 5'd0, 7'd0);
    item.fore_color = 4'hF;
    item.back_color = 4'hF;
    send(item);
    item = cmd_item(CMD_WRITE_CELL, 8'h00, 5'(ROWS - 1), 7'(COLS - 1));
    item.fore_color = 4'h0;
    item.back_color = 4'h0;
    send(item);
    send(cmd_item(CMD_WRITE_CELL, 8'h55, 5'(ROWS), 7'd0));
    send(cmd_item(CMD_WRITE_CELL, 8'hAA, 5'd0, 7'(COLS)));
    send(cmd_item(CMD_READ_CELL, 8'h00, 5'd0, 7'd0));
    send(cmd_item(CMD_READ_CELL, 8'h00, 5'(ROWS - 1), 7'(COLS - 1)));
    send(cmd_item(CMD_READ_CELL, 8'h00, 5'(ROWS), 7'd0));
    send(cmd_item(CMD_SET_CURSOR, 8'h00, 5'h1F, 7'h7F));
    send(cmd_item(CMD_PUT_CHAR, 8'h41, 5'd0, 7'd0));
    send(cmd_item(CMD_READ_CELL, 8'h00, 5'(ROWS - 2), 7'(COLS - 1)));
    send(cmd_item(CMD_PUT_CHAR, CH_NL, 5'd0, 7'd0));
    send(cmd_item(CMD_PUT_CHAR, CH_TAB, 5'd0, 7'd0));
    send(cmd_item(CMD_SET_CURSOR, 8'h00, 5'd3, 7'(COLS - 5)));
    send(cmd_item(CMD_PUT_CHAR, CH_TAB, 5'd0, 7'd0));
    send(cmd_item(CMD_PUT_CHAR, 8'h78, 5'd0, 7'd0));
    send(cmd_item(CMD_PUT_CHAR, CH_CR, 5'd0, 7'd0));
    send(cmd_item(CMD_PUT_CHAR, CH_BS, 5'd0, 7'd0));
    send(cmd_item(CMD_PUT_CHAR, 8'h00, 5'd0, 7'd0));
    send(cmd_item(CMD_PUT_CHAR, CH_BS, 5'd0, 7'd0));
    send(cmd_item(CMD_PUT_CHAR, 8'hFF, 5'd0, 7'd0));
    send(cmd_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0));
    send(cmd_item(CMD_SPARE_FIRST, 8'hFF, 5'h1F, 7'h7F));
    send(cmd_item(CMD_SPARE_LAST, 8'h00, 5'd0, 7'd0));

    // Back-pressure: hold the receiver off while the sender keeps offering,
    // then pause the sender until every result has come back.
    drain();
    hold_pending = 1'b1;
    repeat (24) send(cmd_item(CMD_PUT_CHAR, pick_glyph(), 5'($urandom), 7'($urandom)));
    drain();

    // Random phases, one idle pattern and one attribute value each.
    for (int p = 0; p < 4; p++) begin
      drain();
      phase_attr = (p < 3) ? attr_plan[p] : ATTR_W'($urandom);
      write_attribute(phase_attr);
      sender_idle_pct = sender_idle_plan[p];
      receiver_stall_pct = receiver_stall_plan[p];
      phase_end = sent_count + (ITEM_TARGET - sent_count) / (4 - p);
      while (sent_count < phase_end) run_burst();
    end

    // Wait out the last results, then give a stray result time to show up.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d commands under four idle patterns and five attribute values,",
             sent_count);
    $display("including %0d scrolls and %0d clears.", scrolls, clear_count);
    if (mismatches == 0) begin
      $display("[text_console_engine] OK");
    end else begin
      $display("[text_console_engine] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("[text_console_engine] ERROR");
    $finish;
  end

endmodule
